[rtl/rsmd_pkg.sv]
// Shared types and constants for the relabelled state mismatch distance block.
// Holds the controller state encoding and the command/status bundles.
// Depends on nothing.
package rsmd_pkg;

	localparam int FRAC_W = 16;
	localparam int DIST_W = 17;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_LOAD,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_free;
	} stat_t;

endpackage

[rtl/relabelled_state_mismatch_distance.sv]
// Mismatch distance between two relabelled state sequences: one pair word is
// taken per clock while a sequence streams in. After the word marked last is
// taken, in_ready stays low through the load, divide and finish states while a
// bit-serial restoring divider forms the Q1.16 fraction, one quotient bit per
// cycle; the result word then sits in an output register, and the next sequence
// is taken while it waits to be read. If the result word of the previous
// sequence has still not been read when the divider ends, in_ready stays low
// until that word is taken.
// Depends on rsmd_pkg, rsmd_ctrl and rsmd_datapath.
module relabelled_state_mismatch_distance
	import rsmd_pkg::*;
#(
	parameter int MAX_STATES = 32,
	parameter int MAX_LENGTH = 4096,
	localparam int CW = $clog2(MAX_LENGTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        state_a,
	input  logic              missing_a,
	input  logic [7:0]        state_b,
	input  logic              missing_b,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DIST_W-1:0] distance,
	output logic              undefined,
	output logic              overflow,
	output logic [CW-1:0]     kept_pairs
);

	cmd_t  cmd;
	stat_t stat;

	rsmd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	rsmd_datapath #(
		.MAX_STATES (MAX_STATES),
		.MAX_LENGTH (MAX_LENGTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.state_a    (state_a),
		.missing_a  (missing_a),
		.state_b    (state_b),
		.missing_b  (missing_b),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.distance   (distance),
		.undefined  (undefined),
		.overflow   (overflow),
		.kept_pairs (kept_pairs)
	);

endmodule

[rtl/rsmd_table.sv]
// First-appearance match table for one side of the pair stream.
// Fully parallel compare against the filled entries; no package dependencies.
module rsmd_table #(
	parameter int MAX_STATES = 32,
	localparam int LW = $clog2(MAX_STATES + 1),
	localparam int IW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          clr,
	input  logic [7:0]    code,
	output logic [LW-1:0] label,
	output logic          full_miss
);

	logic [7:0]            entries [MAX_STATES];
	logic [LW-1:0]         fill_q;
	logic [MAX_STATES-1:0] hit_vec;
	logic [LW-1:0]         hit_label;
	logic                  hit;
	logic                  full;

	always_comb begin
		hit_label = '0;
		for (int i = 0; i < MAX_STATES; i++) begin
			hit_vec[i] = (LW'(i) < fill_q) && (entries[i] == code);
			if (hit_vec[i]) begin
				hit_label = hit_label | LW'(i);
			end
		end
	end

	assign hit  = |hit_vec;
	assign full = (fill_q == LW'(MAX_STATES));
	// When the table is full the fill count equals the shared overflow label.
	assign label     = hit ? hit_label : fill_q;
	assign full_miss = en && !hit && full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (clr) begin
			fill_q <= '0;
		end else if (en && !hit && !full) begin
			fill_q <= fill_q + LW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (en && !hit && !full) begin
			entries[fill_q[IW-1:0]] <= code;
		end
	end

endmodule

[rtl/rsmd_ctrl.sv]
// Controller state machine: pair intake, divider sequencing and result hand-off.
// Depends on rsmd_pkg for the state, command and status types.
module rsmd_ctrl
	import rsmd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  last,
	input  stat_t stat,
	output logic  in_ready,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (in_valid && last) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: state_d = ST_DIV;
			ST_DIV: begin
				if (stat.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					state_d = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_RUN: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_LOAD:   cmd.load   = 1'b1;
			ST_DIV:    cmd.step   = 1'b1;
			ST_FINISH: cmd.finish = stat.out_free;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/rsmd_datapath.sv]
// Datapath: two match tables, pair and mismatch counters, a restoring divider
// and the output register. Depends on rsmd_pkg and rsmd_table.
module rsmd_datapath
	import rsmd_pkg::*;
#(
	parameter int MAX_STATES = 32,
	parameter int MAX_LENGTH = 4096,
	localparam int CW = $clog2(MAX_LENGTH + 1),
	localparam int LW = $clog2(MAX_STATES + 1),
	localparam int NW = CW + FRAC_W,
	localparam int SW = $clog2(NW + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic [7:0]        state_a,
	input  logic              missing_a,
	input  logic [7:0]        state_b,
	input  logic              missing_b,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [DIST_W-1:0] distance,
	output logic              undefined,
	output logic              overflow,
	output logic [CW-1:0]     kept_pairs
);

	logic [CW-1:0] pair_q;
	logic [CW-1:0] mismatch_q;
	logic          ovf_q;
	logic          keep;
	logic [LW-1:0] label_a;
	logic [LW-1:0] label_b;
	logic          miss_a;
	logic          miss_b;

	logic [CW-1:0] rem_q;
	logic [NW-1:0] nq_q;
	logic [SW-1:0] step_q;
	logic [CW:0]   trial;
	logic          ge;

	logic          out_valid_q;
	logic [DIST_W-1:0] distance_q;
	logic          undefined_q;
	logic          overflow_q;
	logic [CW-1:0] kept_q;

	// Once the length limit is hit a pair touches neither table nor counters.
	assign keep = cmd.accept && !missing_a && !missing_b && (pair_q < CW'(MAX_LENGTH));

	rsmd_table #(.MAX_STATES(MAX_STATES)) u_table_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (keep),
		.clr       (cmd.finish),
		.code      (state_a),
		.label     (label_a),
		.full_miss (miss_a)
	);

	rsmd_table #(.MAX_STATES(MAX_STATES)) u_table_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (keep),
		.clr       (cmd.finish),
		.code      (state_b),
		.label     (label_b),
		.full_miss (miss_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q     <= '0;
			mismatch_q <= '0;
			ovf_q      <= 1'b0;
		end else if (cmd.finish) begin
			pair_q     <= '0;
			mismatch_q <= '0;
			ovf_q      <= 1'b0;
		end else if (keep) begin
			pair_q <= pair_q + CW'(1);
			if (label_a != label_b) begin
				mismatch_q <= mismatch_q + CW'(1);
			end
			if (miss_a || miss_b) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// One quotient bit per cycle; the numerator carries a half divisor for rounding.
	assign trial = {rem_q, nq_q[NW-1]};
	assign ge    = (trial >= {1'b0, pair_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= '0;
			nq_q  <= NW'({mismatch_q, FRAC_W'(0)}) + NW'(pair_q >> 1);
		end else if (cmd.step) begin
			rem_q <= ge ? CW'(trial - {1'b0, pair_q}) : trial[CW-1:0];
			nq_q  <= {nq_q[NW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load) begin
			step_q <= SW'(NW);
		end else if (cmd.step) begin
			step_q <= step_q - SW'(1);
		end
	end

	assign stat.div_last = (step_q == SW'(1));
	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			undefined_q <= (pair_q == '0);
			distance_q  <= (pair_q == '0) ? '0 : nq_q[DIST_W-1:0];
			overflow_q  <= ovf_q;
			kept_q      <= pair_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign distance   = distance_q;
	assign undefined  = undefined_q;
	assign overflow   = overflow_q;
	assign kept_pairs = kept_q;

`ifndef ASSERT_OFF
	a_mismatch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mismatch_q <= pair_q)
		else $error("mismatch count exceeds pair count");

	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pair_q <= CW'(MAX_LENGTH))
		else $error("pair count beyond length limit");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (out_valid_q && pair_q == '0 && mismatch_q == '0 && !ovf_q))
		else $error("sequence state not cleared after result");

	a_no_keep_while_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load || cmd.step || cmd.finish) |-> !keep)
		else $error("pair kept while divider busy");
`endif

endmodule

[bench/tb_top.sv]
// Self-checking bench for relabelled_state_mismatch_distance: queued pair words are
// driven by a clocked driver and scored against an in-bench distance predictor.
// Depends on rsmd_pkg and the RTL of relabelled_state_mismatch_distance.
module tb_top;
	import rsmd_pkg::*;

	localparam int TABLE_DEPTH = 32;
	localparam int LEN_CAP = 4096;
	localparam int KEPT_W = $clog2(LEN_CAP + 1);

	typedef struct {
		logic [7:0] state_a;
		logic missing_a;
		logic [7:0] state_b;
		logic missing_b;
		logic last;
		int unsigned gap;
		bit drain;
	} pair_word_t;

	typedef struct {
		logic [DIST_W-1:0] distance;
		logic undefined;
		logic overflow;
		logic [KEPT_W-1:0] kept_pairs;
	} distance_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] state_a = '0;
	logic missing_a = 1'b0;
	logic [7:0] state_b = '0;
	logic missing_b = 1'b0;
	logic last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DIST_W-1:0] distance;
	logic undefined;
	logic overflow;
	logic [KEPT_W-1:0] kept_pairs;

	pair_word_t pair_backlog[$];
	distance_word_t pending_distances[$];
	pair_word_t tx_word;
	distance_word_t rx_expect;
	int unsigned idle_run;
	int unsigned rx_stall;
	bit rx_calm;
	int unsigned mismatches;

	// Predictor state: per-side match tables, counters and the spill flag.
	logic [7:0] seen [2][TABLE_DEPTH];
	int unsigned fill [2];
	int unsigned kept;
	int unsigned differ;
	bit spilled;

	relabelled_state_mismatch_distance #(
		.MAX_STATES(TABLE_DEPTH),
		.MAX_LENGTH(LEN_CAP)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.state_a(state_a),
		.missing_a(missing_a),
		.state_b(state_b),
		.missing_b(missing_b),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.distance(distance),
		.undefined(undefined),
		.overflow(overflow),
		.kept_pairs(kept_pairs)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Label of a state on one side: its first-appearance order, or the shared
	// spill label once the table is full.
	function automatic int unsigned relabel(input int side, input logic [7:0] code);
		int unsigned i;
		for (i = 0; i < fill[side]; i++) begin
			if (seen[side][i] == code)
				return i;
		end
		if (fill[side] < TABLE_DEPTH) begin
			seen[side][fill[side]] = code;
			fill[side]++;
			return fill[side] - 1;
		end
		spilled = 1'b1;
		return TABLE_DEPTH;
	endfunction

	function automatic void fold_pair(input pair_word_t w);
		int unsigned la;
		int unsigned lb;
		longint unsigned num;
		distance_word_t r;
		if (!w.missing_a && !w.missing_b && kept < LEN_CAP) begin
			la = relabel(0, w.state_a);
			lb = relabel(1, w.state_b);
			kept++;
			if (la != lb)
				differ++;
		end
		if (w.last) begin
			if (kept == 0) begin
				r.distance = '0;
				r.undefined = 1'b1;
			end else begin
				num = longint'(differ) * 65536 + longint'(kept / 2);
				r.distance = DIST_W'(num / longint'(kept));
				r.undefined = 1'b0;
			end
			r.overflow = spilled;
			r.kept_pairs = KEPT_W'(kept);
			pending_distances.push_back(r);
			fill[0] = 0;
			fill[1] = 0;
			kept = 0;
			differ = 0;
			spilled = 1'b0;
		end
	endfunction

	task automatic queue_pair(input logic [7:0] sa, input logic ma, input logic [7:0] sb,
			input logic mb, input logic lst, input bit calm, input bit drain);
		pair_word_t w;
		w.state_a = sa;
		w.missing_a = ma;
		w.state_b = sb;
		w.missing_b = mb;
		w.last = lst;
		w.gap = calm ? 0 : $urandom_range(0, 11);
		w.drain = drain;
		pair_backlog.push_back(w);
	endtask

	// One random sequence. Styles 0 to 2 keep a mostly consistent mapping between the sides
	// so labels line up; 3 and 4 draw the sides independently; 5 and 6 can pass the table size.
	task automatic queue_sequence(input bit calm, input bit drain);
		logic [7:0] alpha [8];
		logic [7:0] key;
		logic [7:0] sa;
		logic [7:0] sb;
		int unsigned style;
		int unsigned nalpha;
		int unsigned miss_pct;
		int unsigned len;
		int unsigned i;
		int unsigned r;
		style = $urandom_range(0, 6);
		nalpha = $urandom_range(1, 8);
		key = 8'($urandom);
		r = $urandom_range(0, 9);
		miss_pct = (r < 3) ? 0 : (r == 3) ? 100 : $urandom_range(1, 30);
		len = (style >= 5) ? $urandom_range(30, 75) : $urandom_range(1, 40);
		for (i = 0; i < 8; i++)
			alpha[i] = 8'($urandom);
		for (i = 0; i < len; i++) begin
			case (style)
				0, 1, 2: begin
					sa = alpha[$urandom_range(0, nalpha - 1)];
					sb = sa ^ key;
					if ($urandom_range(0, 9) == 0)
						sb = 8'($urandom);
				end
				3: begin
					sa = alpha[$urandom_range(0, nalpha - 1)];
					sb = alpha[$urandom_range(0, nalpha - 1)];
				end
				4: begin
					sa = 8'($urandom);
					sb = 8'($urandom);
				end
				5: begin
					sa = ($urandom_range(0, 2) == 0) ? 8'(key + $urandom_range(0, i)) : 8'(key + i);
					sb = ($urandom_range(0, 2) == 0) ? 8'(key + 3 * $urandom_range(0, i))
						: 8'(key + 3 * i);
				end
				default: begin
					sa = alpha[$urandom_range(0, nalpha - 1)];
					sb = 8'(i) ^ key;
				end
			endcase
			queue_pair(sa, $urandom_range(0, 99) < miss_pct, sb, $urandom_range(0, 99) < miss_pct,
				i == len - 1, calm, drain && i == 0);
		end
	endtask

	// Driver: a new word goes up once the slot frees, its gap is spent and, for a drain word, no result is still expected.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			state_a <= '0;
			missing_a <= 1'b0;
			state_b <= '0;
			missing_b <= 1'b0;
			last <= 1'b0;
			idle_run = 0;
		end else begin
			if (in_valid && in_ready)
				fold_pair(tx_word);
			if ((in_valid && in_ready) || !in_valid) begin
				if (pair_backlog.size() != 0 && idle_run >= pair_backlog[0].gap
						&& !(pair_backlog[0].drain && pending_distances.size() != 0)) begin
					tx_word = pair_backlog.pop_front();
					state_a <= tx_word.state_a;
					missing_a <= tx_word.missing_a;
					state_b <= tx_word.state_b;
					missing_b <= tx_word.missing_b;
					last <= tx_word.last;
					in_valid <= 1'b1;
					idle_run = 0;
				end else begin
					in_valid <= 1'b0;
					idle_run++;
				end
			end
		end
	end

	// Monitor: the stall drawn after each word only counts down while a result waits.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_stall = 0;
			rx_calm = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_distances.size() == 0) begin
					$error("distance word with no expectation waiting");
					mismatches++;
				end else begin
					rx_expect = pending_distances.pop_front();
					if (distance !== rx_expect.distance) begin
						$error("distance: expected %0d, got %0d", rx_expect.distance, distance);
						mismatches++;
					end
					if (undefined !== rx_expect.undefined) begin
						$error("undefined: expected %0d, got %0d", rx_expect.undefined, undefined);
						mismatches++;
					end
					if (overflow !== rx_expect.overflow) begin
						$error("overflow: expected %0d, got %0d", rx_expect.overflow, overflow);
						mismatches++;
					end
					if (kept_pairs !== rx_expect.kept_pairs) begin
						$error("kept_pairs: expected %0d, got %0d", rx_expect.kept_pairs, kept_pairs);
						mismatches++;
					end
				end
				if ($urandom_range(0, 7) == 0)
					rx_calm = !rx_calm;
				rx_stall = rx_calm ? 0 : $urandom_range(0, 11);
			end else if (out_valid && rx_stall != 0) begin
				rx_stall--;
			end
			out_ready <= (rx_stall == 0);
		end
	end

	initial begin
		bit first_seq;
		mismatches = 0;
		fill[0] = 0;
		fill[1] = 0;
		kept = 0;
		differ = 0;
		spilled = 1'b0;

		// Sequences with no kept pair, then the state code extremes.
		queue_pair(8'd0, 1'b1, 8'd255, 1'b0, 1'b1, 1'b0, 1'b0);
		queue_pair(8'd255, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0);
		queue_pair(8'd255, 1'b1, 8'd255, 1'b1, 1'b1, 1'b0, 1'b0);
		queue_pair(8'd255, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0);
		// Crossed labels give half of the pairs as mismatches.
		queue_pair(8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_pair(8'd0, 1'b0, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_pair(8'd255, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_pair(8'd255, 1'b0, 8'd255, 1'b0, 1'b1, 1'b0, 1'b0);
		// Two thirds, which has to round up.
		queue_pair(8'd1, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_pair(8'd1, 1'b0, 8'd2, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_pair(8'd1, 1'b0, 8'd3, 1'b0, 1'b1, 1'b0, 1'b0);
		// Same codes relabelled differently on each side still match.
		queue_pair(8'd170, 1'b0, 8'd85, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_pair(8'd85, 1'b0, 8'd170, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_pair(8'd7, 1'b1, 8'd9, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_pair(8'd170, 1'b0, 8'd85, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_pair(8'd3, 1'b0, 8'd3, 1'b1, 1'b1, 1'b0, 1'b0);

		first_seq = 1'b1;
		while (pair_backlog.size() < 1900) begin
			queue_sequence($urandom_range(0, 3) == 0, first_seq || $urandom_range(0, 9) == 0);
			first_seq = 1'b0;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pair_backlog.size() != 0 || in_valid || pending_distances.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

endmodule
